/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property once reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/bmpq_pkg.sv */
// ----------------------------------------------------------------------------
// bmpq_pkg
// Types and codes shared by the bounded min priority queue modules.
// ----------------------------------------------------------------------------
package bmpq_pkg;

    // Request kinds
    localparam logic [2:0] REQ_ENQUEUE  = 3'd0;
    localparam logic [2:0] REQ_DEQUEUE  = 3'd1;
    localparam logic [2:0] REQ_PEEK_MIN = 3'd2;
    localparam logic [2:0] REQ_PEEK_MAX = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_SUCCESS = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    // Width of the max_size register write data
    localparam int MAX_SIZE_BITS = 5;

    typedef enum logic
    {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic load;    // capture the incoming request
        logic exec;    // apply the held request and load the result
        logic cfg_wr;  // write max_size and empty the queue
    } bmpq_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic out_stall;  // result register is full and not being drained
    } bmpq_stat_t;

endpackage

/* hw/rtl/bounded_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// bounded_min_priority_queue
// Holds up to max_size of the smallest (index, value) pairs, sorted descending.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per transfer. tuser carries the request
//   kind (enqueue, dequeue min, peek min, peek max, clear), tdata carries the
//   index tag and the Q16.16 key. Every request yields exactly one result.
//   Output stream (m_*): tuser carries the status, tdata the peeked pair,
//   the entry count and the empty and full flags after the request.
//   Config channel (cfg_*): writes max_size, clamped to 1..CAPACITY, and
//   empties the queue. Write it only while no request is in flight.
// Timing:
//   A request is captured on acceptance and applied from the EXEC state,
//   which waits while the result register is stalled; the result is
//   registered at the apply step. No new request is taken until the held
//   one is applied. The compare-and-shift across all slots happens then.
// Reset: the queue is empty and max_size is the smaller of CAPACITY and 16.
// Stall: a held result waits in the output register; one more request can be
//   taken meanwhile, and its apply step holds until the result drains.
// ----------------------------------------------------------------------------
module bounded_min_priority_queue
    import bmpq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 24,
    parameter int VALUE_BITS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // request in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // {item_value, item_index} from bit 0: item_index, item_value, zero pad
    input  logic [((INDEX_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // bit 0 up: req_type
    input  logic [2:0]                       s_tuser,
    // result out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // from bit 0: out_index, out_value, entry_count_out, is_empty, is_full, zero pad
    output logic [((INDEX_BITS+VALUE_BITS+$clog2(CAPACITY+1)+3+7)/8)*8-1:0] m_tdata,
    // bit 0 up: status
    output logic [1:0]                       m_tuser,
    // max_size write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [MAX_SIZE_BITS-1:0]         cfg_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IN_W   = INDEX_BITS + VALUE_BITS;
    localparam int IN_PW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = INDEX_BITS + 1 + VALUE_BITS + CNT_W + 2;
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

    bmpq_cmd_t  cmd;
    bmpq_stat_t stat;

    logic signed [INDEX_BITS:0]   out_index;
    logic signed [VALUE_BITS-1:0] out_value;
    logic [CNT_W-1:0]             entry_count_out;
    logic                         is_empty;
    logic                         is_full;
    logic [1:0]                   status;

    // sequencer: accept, wait for room, apply
    bmpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // slot array and result register
    bmpq_datapath #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (s_tuser),
        .item_index      (s_tdata[INDEX_BITS-1:0]),
        .item_value      (s_tdata[IN_W-1:INDEX_BITS]),
        .cfg_data        (cfg_data),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .status          (status),
        .out_index       (out_index),
        .out_value       (out_value),
        .entry_count_out (entry_count_out),
        .is_empty        (is_empty),
        .is_full         (is_full)
    );

    // pack the result; pad bits above the fields stay zero
    assign m_tdata = OUT_PW'({is_full, is_empty, entry_count_out, out_value, out_index});
    assign m_tuser = status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "assert_macros.svh"

    // a taken request blocks the next one until it is applied
    `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")

    // a fresh result only follows an apply step
    `ASSERT_CLK(a_result_from_apply, $rose(m_tvalid) |-> $past(!s_tready), "result without a request")

    // max_size is at least one, so a result is never both empty and full
    `ASSERT_CLK(a_empty_full_excl, m_tvalid |-> !(is_empty && is_full), "queue both empty and full")

    // only a successful peek returns a real index tag
    `ASSERT_CLK(a_index_none, (m_tvalid && status != STAT_SUCCESS) |-> (out_index == '1), "index tag on a failed request")

    // the input packing leaves no unused byte
    `ASSERT_ALWAYS(a_in_pack, IN_PW - IN_W < 8, "input pack width")

endmodule

/* hw/rtl/bmpq_ctrl.sv */
// ----------------------------------------------------------------------------
// bmpq_ctrl
// Sequencer: takes one request, waits for room in the result register, fires.
// ----------------------------------------------------------------------------
module bmpq_ctrl
    import bmpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  bmpq_stat_t stat,
    output bmpq_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            CTRL_IDLE:
            begin
                s_tready   = 1'b1;
                cfg_ready  = 1'b1;
                cmd.load   = s_tvalid;
                cmd.cfg_wr = cfg_valid;
                if (s_tvalid)
                begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                // hold until the result register can take the answer
                if (!stat.out_stall)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bmpq_datapath.sv */
// ----------------------------------------------------------------------------
// bmpq_datapath
// Sorted slot array with per-slot compare-and-shift, counters, result register.
// ----------------------------------------------------------------------------
module bmpq_datapath
    import bmpq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 24,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmpq_cmd_t                    cmd,
    output bmpq_stat_t                   stat,
    input  logic [2:0]                   req_type,
    input  logic [INDEX_BITS-1:0]        item_index,
    input  logic signed [VALUE_BITS-1:0] item_value,
    input  logic [MAX_SIZE_BITS-1:0]     cfg_data,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [1:0]                   status,
    output logic signed [INDEX_BITS:0]   out_index,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic [CNT_W-1:0]             entry_count_out,
    output logic                         is_empty,
    output logic                         is_full
);

    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W   = (CNT_W > MAX_SIZE_BITS) ? CNT_W : MAX_SIZE_BITS;
    localparam int RST_MAX = (CAPACITY < 16) ? CAPACITY : 16;
    localparam logic signed [VALUE_BITS-1:0] NEG_ONE_Q16 = VALUE_BITS'(-64'sd65536);

    // held request
    logic [2:0]            req_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // slot array, slot 0 holds the maximum
    logic [INDEX_BITS-1:0] slot_idx_reg [CAPACITY];
    logic [VALUE_BITS-1:0] slot_val_reg [CAPACITY];
    logic [INDEX_BITS-1:0] slot_idx_next [CAPACITY];
    logic [VALUE_BITS-1:0] slot_val_next [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] max_reg;
    logic [CMP_W-1:0] cfg_sat;

    // result register
    logic                         m_valid_reg;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic signed [INDEX_BITS:0]   oidx_reg;
    logic signed [INDEX_BITS:0]   oidx_next;
    logic signed [VALUE_BITS-1:0] oval_reg;
    logic signed [VALUE_BITS-1:0] oval_next;
    logic [CNT_W-1:0]             ocnt_reg;
    logic                         oempty_reg;
    logic                         ofull_reg;

    logic [CAPACITY-1:0] gt;
    logic                q_full;
    logic                neg;
    logic                slot_we;
    logic [SLOT_W-1:0]   min_slot;
    logic [CNT_W-1:0]    count_dec;

    assign stat.out_stall = m_valid_reg && !m_tready;

    assign q_full    = CMP_W'(count_reg) >= max_reg;
    assign neg       = val_reg[VALUE_BITS-1];
    assign count_dec = count_reg - CNT_W'(1);
    assign min_slot  = count_dec[SLOT_W-1:0];

    // saturate the written bound into 1..CAPACITY
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_sat = CMP_W'(1);
        end
        else if (CMP_W'(cfg_data) > CMP_W'(CAPACITY))
        begin
            cfg_sat = CMP_W'(CAPACITY);
        end
        else
        begin
            cfg_sat = CMP_W'(cfg_data);
        end
    end

    // Every occupied slot compares against the new key; the set bits form a
    // prefix because the array is sorted descending.
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_slot
            logic                  up_gt;
            logic                  dn_gt;
            logic [INDEX_BITS-1:0] up_idx;
            logic [VALUE_BITS-1:0] up_val;
            logic [INDEX_BITS-1:0] dn_idx;
            logic [VALUE_BITS-1:0] dn_val;

            assign gt[k] = (CNT_W'(k) < count_reg) && (val_reg < slot_val_reg[k]);

            if (k == CAPACITY - 1)
            begin : g_top
                assign up_gt  = 1'b0;
                assign up_idx = slot_idx_reg[k];
                assign up_val = slot_val_reg[k];
            end
            else
            begin : g_mid
                assign up_gt  = gt[k+1];
                assign up_idx = slot_idx_reg[k+1];
                assign up_val = slot_val_reg[k+1];
            end

            if (k == 0)
            begin : g_first
                assign dn_gt  = 1'b1;
                assign dn_idx = slot_idx_reg[k];
                assign dn_val = slot_val_reg[k];
            end
            else
            begin : g_rest
                assign dn_gt  = gt[k-1];
                assign dn_idx = slot_idx_reg[k-1];
                assign dn_val = slot_val_reg[k-1];
            end

            always_comb
            begin
                slot_idx_next[k] = slot_idx_reg[k];
                slot_val_next[k] = slot_val_reg[k];
                if (q_full)
                begin
                    // evict the maximum: shift the larger keys toward slot 0
                    if (up_gt)
                    begin
                        slot_idx_next[k] = up_idx;
                        slot_val_next[k] = up_val;
                    end
                    else if (gt[k])
                    begin
                        slot_idx_next[k] = idx_reg;
                        slot_val_next[k] = val_reg;
                    end
                end
                else if (!gt[k])
                begin
                    // open a gap ahead of equal and smaller keys
                    if (dn_gt)
                    begin
                        slot_idx_next[k] = idx_reg;
                        slot_val_next[k] = val_reg;
                    end
                    else
                    begin
                        slot_idx_next[k] = dn_idx;
                        slot_val_next[k] = dn_val;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (slot_we)
                begin
                    slot_idx_reg[k] <= slot_idx_next[k];
                    slot_val_reg[k] <= slot_val_next[k];
                end
            end
        end
    endgenerate

    // request decode
    always_comb
    begin
        status_next = STAT_SUCCESS;
        oidx_next   = '1;
        oval_next   = '0;
        count_next  = count_reg;
        slot_we     = 1'b0;
        case (req_reg)
            REQ_ENQUEUE:
            begin
                if (neg)
                begin
                    status_next = STAT_INVALID;
                end
                else if (q_full)
                begin
                    status_next = STAT_FULL;
                    slot_we     = cmd.exec && gt[0];
                end
                else
                begin
                    slot_we    = cmd.exec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DEQUEUE:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    count_next = count_dec;
                end
            end
            REQ_PEEK_MIN:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                    oval_next   = NEG_ONE_Q16;
                end
                else
                begin
                    oidx_next = {1'b0, slot_idx_reg[min_slot]};
                    oval_next = slot_val_reg[min_slot];
                end
            end
            REQ_PEEK_MAX:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                    oval_next   = NEG_ONE_Q16;
                end
                else
                begin
                    oidx_next = {1'b0, slot_idx_reg[0]};
                    oval_next = slot_val_reg[0];
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = STAT_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            idx_reg <= item_index;
            val_reg <= item_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= CMP_W'(RST_MAX);
        end
        else if (cmd.cfg_wr)
        begin
            count_reg <= '0;
            max_reg   <= cfg_sat;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            oidx_reg   <= oidx_next;
            oval_reg   <= oval_next;
            ocnt_reg   <= count_next;
            oempty_reg <= (count_next == '0);
            ofull_reg  <= (CMP_W'(count_next) >= max_reg);
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign status          = status_reg;
    assign out_index       = oidx_reg;
    assign out_value       = oval_reg;
    assign entry_count_out = ocnt_reg;
    assign is_empty        = oempty_reg;
    assign is_full         = ofull_reg;

endmodule
